FILE: hw/rtl/gww_pkg.sv
// Shared types and constants for the greedy word wrapper.
// Payload structs, controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

    localparam int         MAX_WORD_DEF   = 32;
    localparam logic [7:0] CH_SPACE       = 8'd32;
    localparam logic [7:0] CH_NEWLINE     = 8'd10;
    localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_last;
    } t_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_end;
        logic       line_end;
        logic       word_cut;
    } t_out;

    typedef struct packed {
        logic accept;
        logic plan;
        logic emit_held;
        logic emit_word;
        logic finish;
        logic phase2;
    } t_cmd;

    typedef struct packed {
        logic in_bnd;
        logic in_last;
        logic held_valid;
        logic wl_zero;
        logic word_done;
        logic out_free;
        logic last;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/greedy_word_wrapper.sv
// Top level of the greedy word wrapper: controller plus datapath.
// Depends on gww_pkg, gww_ctrl, gww_datapath.
//
// Bytes arrive on the input channel tagged with line_last; words are
// buffered (up to MAX_WORD bytes, the rest dropped and flagged) and released
// with the boundary byte held before them, that byte becoming a newline when
// the word would run past line_width. A byte that closes no word and no line
// is taken without stalling the input. A byte that closes a word is taken and
// then stalls the input through a planning step and the emission of each
// byte (held byte and word bytes); a boundary byte that also ends its line
// adds a second planning step and the byte it releases. This sequence comes
// from the single read port of the word buffer and the single output
// register; output stalls lengthen it. The word buffer powers up undefined
// and needs no clearing pass. line_width resets to 80 and is written through
// the configuration channel, always ready.
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrapper #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire gww_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output gww_pkg::t_out     o_out_data,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_data
);

    gww_pkg::t_cmd cmd;
    gww_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    gww_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gww_datapath #(
        .MAX_WORD (MAX_WORD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gww_datapath.sv
// Datapath of the word wrapper: word buffer, column and wrap logic,
// held boundary byte, line width register and output register.
// Depends on gww_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gww_datapath #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gww_pkg::t_cmd i_cmd,
    output gww_pkg::t_sts      o_sts,
    input  wire gww_pkg::t_in  i_in_data,
    input  wire logic          i_cfg_valid,
    input  wire logic [7:0]    i_cfg_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output gww_pkg::t_out      o_out_data
);

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int AW = $clog2(MAX_WORD);
    localparam int PW = ((LW > 8) ? LW : 8) + 1;

    logic [7:0]    r_mem [MAX_WORD];
    logic [7:0]    r_q;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [LW-1:0] r_wl;
    logic [7:0]    r_column;
    logic [7:0]    r_line_width;
    logic [7:0]    r_held;
    logic          r_held_valid;
    logic          r_cut;
    logic [7:0]    r_ch;
    logic          r_last;
    logic          r_out_valid;
    gww_pkg::t_out r_out;

    logic          in_bnd;
    logic          needs;
    logic [PW-1:0] pros;
    logic          wrap;
    logic          wl_zero;
    logic          word_done;
    logic          more;
    logic          out_free;
    logic          room;

    assign in_bnd    = (i_in_data.char_in == gww_pkg::CH_SPACE)
                    || (i_in_data.char_in == gww_pkg::CH_NEWLINE);
    assign needs     = (r_column != 8'd0);
    assign pros      = PW'(r_column) + PW'(needs) + PW'(r_wl);
    assign wrap      = (pros > PW'(r_line_width));
    assign wl_zero   = (r_wl == '0);
    assign word_done = ((LW'(r_idx) + LW'(1)) == r_wl);
    assign more      = !i_cmd.phase2 && r_last;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign room      = (r_wl < LW'(MAX_WORD));

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.plan) begin
            n_idx = '0;
        end else if (i_cmd.emit_word && !word_done) begin
            n_idx = r_idx + AW'(1);
        end
    end

    // word buffer, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !in_bnd && room) begin
            r_mem[r_wl[AW-1:0]] <= i_in_data.char_in;
        end
        r_q   <= r_mem[n_idx];
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch   <= i_in_data.char_in;
            r_last <= i_in_data.line_last;
        end
        if (i_cmd.emit_held) begin
            r_out.char_out <= r_held;
            r_out.run_end  <= wl_zero && !more;
            r_out.line_end <= wl_zero && !more && r_last;
            r_out.word_cut <= 1'b0;
        end else if (i_cmd.emit_word) begin
            r_out.char_out <= r_q;
            r_out.run_end  <= word_done && !more;
            r_out.line_end <= word_done && !more && r_last;
            r_out.word_cut <= r_cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= gww_pkg::LINE_WIDTH_RST;
            r_wl         <= '0;
            r_column     <= 8'd0;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_cut        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_width <= i_cfg_data;
            end
            if (i_cmd.accept && !in_bnd) begin
                if (room) begin
                    r_wl <= r_wl + LW'(1);
                end else begin
                    r_cut <= 1'b1;
                end
            end
            if (i_cmd.plan && !wl_zero) begin
                if (wrap) begin
                    r_column <= 8'(PW'(r_wl));
                    if (needs && r_held_valid) begin
                        r_held <= gww_pkg::CH_NEWLINE;
                    end
                end else begin
                    r_column <= pros[7:0];
                end
            end
            if (i_cmd.finish) begin
                r_wl  <= '0;
                r_cut <= 1'b0;
                if (i_cmd.phase2) begin
                    r_held_valid <= 1'b0;
                    r_column     <= 8'd0;
                end else begin
                    r_held       <= r_ch;
                    r_held_valid <= 1'b1;
                end
            end
            if (i_cmd.emit_held || i_cmd.emit_word) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_bnd     = in_bnd;
    assign o_sts.in_last    = i_in_data.line_last;
    assign o_sts.held_valid = r_held_valid;
    assign o_sts.wl_zero    = wl_zero;
    assign o_sts.word_done  = word_done;
    assign o_sts.out_free   = out_free;
    assign o_sts.last       = r_last;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/gww_ctrl.sv
// Controller of the word wrapper: sequences accept, wrap planning and
// emission of the held byte and the buffered word.
// Depends on gww_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gww_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire gww_pkg::t_sts i_sts,
    output gww_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PLAN = 4'b0010,
        S_HELD = 4'b0100,
        S_WORD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_phase2;
    logic   n_phase2;

    always_comb begin
        n_state   = r_state;
        n_phase2  = r_phase2;
        o_cmd     = '0;
        o_cmd.phase2 = r_phase2;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_bnd) begin
                        n_state  = S_PLAN;
                        n_phase2 = 1'b0;
                    end else if (i_sts.in_last) begin
                        n_state  = S_PLAN;
                        n_phase2 = 1'b1;
                    end
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                if (i_sts.held_valid) begin
                    n_state = S_HELD;
                end else if (!i_sts.wl_zero) begin
                    n_state = S_WORD;
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            S_HELD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_held = 1'b1;
                    if (!i_sts.wl_zero) begin
                        n_state = S_WORD;
                    end else begin
                        o_cmd.finish = 1'b1;
                    end
                end
            end
            S_WORD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_word = 1'b1;
                    if (i_sts.word_done) begin
                        o_cmd.finish = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // end of a close: run the line-end close next, or go idle
        if (o_cmd.finish) begin
            if (!r_phase2 && i_sts.last) begin
                n_state  = S_PLAN;
                n_phase2 = 1'b1;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase2 <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase2 <= n_phase2;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/gww_checker.sv
// Port-level assertions for the greedy word wrapper, bound to the top.
// Depends on gww_pkg and greedy_word_wrapper.
`timescale 1ns / 1ps
`default_nettype none

module gww_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_stall,
    input wire gww_pkg::t_in  i_in_data,
    input wire logic          i_out_valid,
    input wire logic          i_out_stall,
    input wire gww_pkg::t_out i_out_data
);

    logic in_take;
    logic closes;

    assign in_take = i_in_valid && !i_in_stall;
    assign closes  = (i_in_data.char_in == gww_pkg::CH_SPACE)
                  || (i_in_data.char_in == gww_pkg::CH_NEWLINE)
                  || i_in_data.line_last;

    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.line_end |-> i_out_data.run_end)
        else $error("line_end without run_end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output request changed");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && closes |=> i_in_stall)
        else $error("closing byte did not start emission");

    a_plain_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && !closes |=> !i_in_stall)
        else $error("plain byte stalled the input");

endmodule

bind greedy_word_wrapper gww_checker u_gww_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
